// ===== src/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg: breath cycle sequencer shared definitions
// Item layouts, phase codes, inspiration kinds, register indexes and the
// backup period lookup table.
// ----------------------------------------------------------------------------
package bcs_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int RATE_BITS      = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int PHASE_BITS     = 3;
   localparam int KIND_BITS      = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BACKUP_RATE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_APNEA_TIME  = 1'b1;

   // inspiration kinds
   localparam logic [KIND_BITS-1:0] INSP_NONE    = 2'd0;
   localparam logic [KIND_BITS-1:0] INSP_PATIENT = 2'd1;
   localparam logic [KIND_BITS-1:0] INSP_CONTROL = 2'd2;

   // reported phase codes
   localparam logic [PHASE_BITS-1:0] CODE_ENTRY       = 3'd0;
   localparam logic [PHASE_BITS-1:0] CODE_ASSIST_EXH  = 3'd1;
   localparam logic [PHASE_BITS-1:0] CODE_ASSIST_INSP = 3'd2;
   localparam logic [PHASE_BITS-1:0] CODE_CTRL_INSP   = 3'd3;
   localparam logic [PHASE_BITS-1:0] CODE_CTRL_EXH    = 3'd4;

   localparam logic [RATE_BITS-1:0]  RESET_RATE  = 6'd12;
   localparam logic [FIELD_BITS-1:0] RESET_APNEA = 16'd20000;

   typedef enum logic [4:0] {
      PH_ENTRY       = 5'b00001,
      PH_ASSIST_EXH  = 5'b00010,
      PH_ASSIST_INSP = 5'b00100,
      PH_CTRL_INSP   = 5'b01000,
      PH_CTRL_EXH    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                  enter_mode;
      logic                  prior_exhale_done;
      logic                  insp_trigger;
      logic                  exp_trigger;
      logic [FIELD_BITS-1:0] ti_min_ms;
      logic [FIELD_BITS-1:0] ti_max_ms;
      logic                  high_pressure;
      logic                  adjusting;
      logic                  backup_off;
      logic                  insp_sens_off;
   } req_item_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  insp_type;
      logic [PHASE_BITS-1:0] phase_now;
      logic [FIELD_BITS-1:0] ti_measured;
      logic                  ti_valid;
      logic [FIELD_BITS-1:0] te_measured;
      logic                  te_valid;
      logic                  copy_settings;
      logic                  clear_peak_flow;
   } rsp_item_type;

   // 60000 / rate, a rate of zero taken as one
   localparam logic [FIELD_BITS-1:0] PERIOD_TABLE [0:63] = '{
      16'd60000, 16'd60000, 16'd30000, 16'd20000, 16'd15000, 16'd12000, 16'd10000, 16'd8571,
      16'd7500,  16'd6666,  16'd6000,  16'd5454,  16'd5000,  16'd4615,  16'd4285,  16'd4000,
      16'd3750,  16'd3529,  16'd3333,  16'd3157,  16'd3000,  16'd2857,  16'd2727,  16'd2608,
      16'd2500,  16'd2400,  16'd2307,  16'd2222,  16'd2142,  16'd2068,  16'd2000,  16'd1935,
      16'd1875,  16'd1818,  16'd1764,  16'd1714,  16'd1666,  16'd1621,  16'd1578,  16'd1538,
      16'd1500,  16'd1463,  16'd1428,  16'd1395,  16'd1363,  16'd1333,  16'd1304,  16'd1276,
      16'd1250,  16'd1224,  16'd1200,  16'd1176,  16'd1153,  16'd1132,  16'd1111,  16'd1090,
      16'd1071,  16'd1052,  16'd1034,  16'd1016,  16'd1000,  16'd983,   16'd967,   16'd952
   };

endpackage

// ===== src/bcs_if.sv =====
// ----------------------------------------------------------------------------
// bcs_if: breath cycle sequencer channels
// Tick request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface bcs_req_if;
   import bcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  enter_mode;
   logic                  prior_exhale_done;
   logic                  insp_trigger;
   logic                  exp_trigger;
   logic [FIELD_BITS-1:0] ti_min_ms;
   logic [FIELD_BITS-1:0] ti_max_ms;
   logic                  high_pressure;
   logic                  adjusting;
   logic                  backup_off;
   logic                  insp_sens_off;

   modport source (
      output valid, enter_mode, prior_exhale_done, insp_trigger, exp_trigger,
             ti_min_ms, ti_max_ms, high_pressure, adjusting, backup_off, insp_sens_off,
      input  ready
   );
   modport sink (
      input  valid, enter_mode, prior_exhale_done, insp_trigger, exp_trigger,
             ti_min_ms, ti_max_ms, high_pressure, adjusting, backup_off, insp_sens_off,
      output ready
   );
endinterface

interface bcs_rsp_if;
   import bcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  insp_type;
   logic [PHASE_BITS-1:0] phase_now;
   logic [FIELD_BITS-1:0] ti_measured;
   logic                  ti_valid;
   logic [FIELD_BITS-1:0] te_measured;
   logic                  te_valid;
   logic                  copy_settings;
   logic                  clear_peak_flow;

   modport source (
      output valid, insp_type, phase_now, ti_measured, ti_valid, te_measured, te_valid,
             copy_settings, clear_peak_flow,
      input  ready
   );
   modport sink (
      input  valid, insp_type, phase_now, ti_measured, ti_valid, te_measured, te_valid,
             copy_settings, clear_peak_flow,
      output ready
   );
endinterface

interface bcs_csr_if;
   import bcs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/breath_cycle_sequencer.sv =====
// ----------------------------------------------------------------------------
// breath_cycle_sequencer: five-phase breath cycle stepper
// One millisecond tick item in, one status item out per tick.
// ----------------------------------------------------------------------------
// Accepts one tick item every clock cycle while the result side takes items,
// and returns one result item per tick: the tick is held in an input
// register, stepped through the phase logic and counters, and held in a result
// register until taken. While a result waits, the input register takes at most
// one more item and then holds it, so the sustained rate is one item per cycle
// whenever the result side takes items. Register writes are always ready; a
// backup rate write looks up the backup period in a 64-entry table in the same
// cycle. Elapsed counters are COUNT_BITS wide, saturate at their maximum, and
// reported durations clip at 65535.
// ----------------------------------------------------------------------------
module breath_cycle_sequencer #(
   parameter int COUNT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   bcs_req_if.sink   req_bus,
   bcs_rsp_if.source rsp_bus,
   bcs_csr_if.sink   csr_bus
);
   import bcs_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] clip(input logic [COUNT_BITS-1:0] c);
      logic [CMP_BITS-1:0] wide;
      wide = CMP_BITS'(c);
      return (wide > CMP_BITS'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}} : wide[FIELD_BITS-1:0];
   endfunction

   req_item_type          in_ff;
   logic                  in_valid_ff;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   phase_type             phase_ff, phase_in, cur_phase;
   logic                  done_ff, done_in, cur_done;
   logic                  prev_boff_ff;
   logic                  memo_ff, memo_in;
   logic [COUNT_BITS-1:0] exh_ff, exh_in, exh_inc;
   logic [COUNT_BITS-1:0] inh_ff, inh_in, inh_inc;
   logic [COUNT_BITS-1:0] per_ff, per_in, per_inc;
   logic [COUNT_BITS-1:0] ti_hold_ff, ti_hold_in;
   logic [COUNT_BITS-1:0] te_hold_ff, te_hold_in;
   logic [FIELD_BITS-1:0] period_ff;
   logic [FIELD_BITS-1:0] apnea_ff;

   logic advance, req_take, csr_take;
   logic boff_rise, trig, timeout, insp_end;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_take = csr_bus.valid && csr_bus.ready;

   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      exh_inc   = sat_inc(exh_ff);
      inh_inc   = sat_inc(inh_ff);
      per_inc   = sat_inc(per_ff);
      cur_phase = in_ff.enter_mode ? PH_ENTRY : phase_ff;
      cur_done  = in_ff.enter_mode ? in_ff.prior_exhale_done : done_ff;
      boff_rise = !prev_boff_ff && in_ff.backup_off;
      trig      = in_ff.insp_trigger && !in_ff.insp_sens_off
                  && !(in_ff.adjusting && memo_ff);
      timeout   = (cur_phase == PH_ASSIST_EXH)
                  ? (!in_ff.backup_off && CMP_BITS'(exh_inc) >= CMP_BITS'(apnea_ff))
                  : ((!in_ff.backup_off && CMP_BITS'(per_inc) >= CMP_BITS'(period_ff))
                     || boff_rise);
      insp_end  = (in_ff.exp_trigger && CMP_BITS'(inh_inc) >= CMP_BITS'(in_ff.ti_min_ms))
                  || CMP_BITS'(inh_inc) >= CMP_BITS'(in_ff.ti_max_ms)
                  || in_ff.high_pressure;

      phase_in   = cur_phase;
      done_in    = cur_done;
      memo_in    = memo_ff;
      exh_in     = exh_inc;
      inh_in     = inh_inc;
      per_in     = per_inc;
      ti_hold_in = ti_hold_ff;
      te_hold_in = te_hold_ff;
      rsp_in     = '0;
      rsp_in.insp_type = INSP_NONE;

      case (cur_phase)
         PH_ENTRY: begin
            if (!cur_done) begin
               exh_in   = '0;
               phase_in = PH_ASSIST_EXH;
            end else begin
               inh_in               = '0;
               rsp_in.insp_type     = INSP_PATIENT;
               rsp_in.copy_settings = 1'b1;
               phase_in             = PH_ASSIST_INSP;
            end
            rsp_in.clear_peak_flow = 1'b1;
         end
         PH_ASSIST_EXH, PH_CTRL_EXH: begin
            if (trig) begin
               rsp_in.insp_type = INSP_PATIENT;
               done_in          = 1'b1;
               phase_in         = PH_ASSIST_INSP;
            end else if (timeout) begin
               rsp_in.insp_type = INSP_CONTROL;
               done_in          = 1'b1;
               phase_in         = PH_CTRL_INSP;
            end
            if (cur_phase == PH_ASSIST_EXH && !in_ff.adjusting) begin
               memo_in = in_ff.insp_sens_off;
            end
            if (done_in) begin
               te_hold_in           = exh_inc;
               rsp_in.te_valid      = 1'b1;
               inh_in               = '0;
               per_in               = '0;
               rsp_in.copy_settings = 1'b1;
            end
            rsp_in.clear_peak_flow = 1'b1;
         end
         PH_ASSIST_INSP, PH_CTRL_INSP: begin
            if (insp_end) begin
               ti_hold_in      = inh_inc;
               rsp_in.ti_valid = 1'b1;
               exh_in          = '0;
               done_in         = 1'b0;
               phase_in        = (cur_phase == PH_ASSIST_INSP) ? PH_ASSIST_EXH : PH_CTRL_EXH;
            end
         end
         default: begin
            phase_in               = PH_CTRL_EXH;
            rsp_in.clear_peak_flow = 1'b1;
         end
      endcase

      case (phase_in)
         PH_ENTRY:       rsp_in.phase_now = CODE_ENTRY;
         PH_ASSIST_EXH:  rsp_in.phase_now = CODE_ASSIST_EXH;
         PH_ASSIST_INSP: rsp_in.phase_now = CODE_ASSIST_INSP;
         PH_CTRL_INSP:   rsp_in.phase_now = CODE_CTRL_INSP;
         default:        rsp_in.phase_now = CODE_CTRL_EXH;
      endcase
      rsp_in.ti_measured = clip(ti_hold_in);
      rsp_in.te_measured = clip(te_hold_in);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         in_ff.enter_mode        <= req_bus.enter_mode;
         in_ff.prior_exhale_done <= req_bus.prior_exhale_done;
         in_ff.insp_trigger      <= req_bus.insp_trigger;
         in_ff.exp_trigger       <= req_bus.exp_trigger;
         in_ff.ti_min_ms         <= req_bus.ti_min_ms;
         in_ff.ti_max_ms         <= req_bus.ti_max_ms;
         in_ff.high_pressure     <= req_bus.high_pressure;
         in_ff.adjusting         <= req_bus.adjusting;
         in_ff.backup_off        <= req_bus.backup_off;
         in_ff.insp_sens_off     <= req_bus.insp_sens_off;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // breath state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ENTRY;
         done_ff      <= 1'b0;
         prev_boff_ff <= 1'b0;
         memo_ff      <= 1'b0;
         exh_ff       <= '0;
         inh_ff       <= '0;
         per_ff       <= '0;
         ti_hold_ff   <= '0;
         te_hold_ff   <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         prev_boff_ff <= in_ff.backup_off;
         memo_ff      <= memo_in;
         exh_ff       <= exh_in;
         inh_ff       <= inh_in;
         per_ff       <= per_in;
         ti_hold_ff   <= ti_hold_in;
         te_hold_ff   <= te_hold_in;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_TABLE[RESET_RATE];
         apnea_ff  <= RESET_APNEA;
      end else if (csr_take) begin
         case (csr_bus.index)
            CSR_BACKUP_RATE: period_ff <= PERIOD_TABLE[csr_bus.data[RATE_BITS-1:0]];
            CSR_APNEA_TIME:  apnea_ff  <= csr_bus.data[FIELD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.insp_type       = rsp_ff.insp_type;
   assign rsp_bus.phase_now       = rsp_ff.phase_now;
   assign rsp_bus.ti_measured     = rsp_ff.ti_measured;
   assign rsp_bus.ti_valid        = rsp_ff.ti_valid;
   assign rsp_bus.te_measured     = rsp_ff.te_measured;
   assign rsp_bus.te_valid        = rsp_ff.te_valid;
   assign rsp_bus.copy_settings   = rsp_ff.copy_settings;
   assign rsp_bus.clear_peak_flow = rsp_ff.clear_peak_flow;

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("stepped item produced no result");

   a_ti_ends_insp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ti_valid |->
         (rsp_ff.phase_now == CODE_ASSIST_EXH || rsp_ff.phase_now == CODE_CTRL_EXH))
      else $error("ti strobe outside an exhalation phase");

   a_te_copies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.te_valid |-> rsp_ff.copy_settings && !rsp_ff.ti_valid)
      else $error("te strobe without settings copy");

   a_kind_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.insp_type != INSP_NONE |->
         ((rsp_ff.insp_type == INSP_PATIENT && rsp_ff.phase_now == CODE_ASSIST_INSP)
          || (rsp_ff.insp_type == INSP_CONTROL && rsp_ff.phase_now == CODE_CTRL_INSP)))
      else $error("inspiration kind disagrees with phase");

endmodule
